// ===== src/editor_event_line_parser_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the event line parser
// Clocked, reset-qualified property wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef EDITOR_EVENT_LINE_PARSER_UNIT_ASSERT_SVH
`define EDITOR_EVENT_LINE_PARSER_UNIT_ASSERT_SVH

// same-cycle implication
`define EELP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define EELP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/eelp_pkg.sv =====
// ----------------------------------------------------------------------------
// eelp_pkg
// Types and constants shared by the event line parser and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package eelp_pkg;

    localparam int unsigned NUM_W   = 31;
    localparam int unsigned TDATA_W = 136;
    localparam logic [NUM_W-1:0] SAT31 = {NUM_W{1'b1}};

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_NL    = 8'h0a;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // chord arguments still to come
    localparam logic [1:0] CHORD_NONE = 2'd0;
    localparam logic [1:0] CHORD_ONE  = 2'd1;
    localparam logic [1:0] CHORD_TWO  = 2'd2;

    typedef enum logic [2:0] {
        PH_ORIGIN,
        PH_TYPE,
        PH_NUM0,
        PH_NUM1,
        PH_NUM2,
        PH_NUM3,
        PH_TEXT,
        PH_NEWLINE
    } phase_t;

    typedef enum logic [1:0] {
        KIND_TEXT,
        KIND_EVENT,
        KIND_ERROR
    } kind_t;

    typedef enum logic [1:0] {
        ROLE_PRIMARY,
        ROLE_EXPANSION,
        ROLE_CHORD1,
        ROLE_CHORD2
    } role_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_BAD_NUMBER,
        ST_TOO_LONG,
        ST_NO_NEWLINE
    } status_t;

    typedef struct packed {
        kind_t            kind;
        role_t            role;
        logic [7:0]       origin_char;
        logic [7:0]       event_type;
        logic [NUM_W-1:0] first_pos;
        logic [NUM_W-1:0] last_pos;
        logic [NUM_W-1:0] flag_bits;
        logic [7:0]       rune_count;
        logic [7:0]       text_byte;
        logic             rune_end;
        status_t          status;
    } result_t;

endpackage

`default_nettype wire

// ===== src/editor_event_line_parser_unit.sv =====
// ----------------------------------------------------------------------------
// editor_event_line_parser_unit
// Byte-wise parser for editor event lines: passes text bytes with rune-end
// marks, emits an event record at each newline and a sticky error word.
// ----------------------------------------------------------------------------
// Each accepted word is registered, via the skid register while the output stalls.
// Throughput: one byte per cycle while s_tready is high; the state updates in one pass.
// Output is a result register plus a skid register, so s_tready only drops
// when both hold words, i.e. the cycle after a new result meets a stalled word.
// Reset (aresetn low, synchronous) returns the parser to the origin byte,
// clears the sticky error and empties both output registers.
`default_nettype none

module editor_event_line_parser_unit #(
    parameter int MAX_RUNES = 256
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // [7:0] byte_in
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [1:0] role, [9:2] origin_char, [17:10] event_type, [48:18] first_pos,
    // [79:49] last_pos, [110:80] flag_bits, [118:111] rune_count,
    // [126:119] text_byte, [127] rune_end, [129:128] status, [135:130] zero
    output logic [135:0]      m_tdata,
    output logic [1:0]        m_tuser    // [1:0] kind
);

    localparam int unsigned NW = eelp_pkg::NUM_W;
    localparam logic [NW-1:0] RUNE_LIMIT = NW'(MAX_RUNES);

    // parser state
    eelp_pkg::phase_t phase_reg, phase_next;
    logic [NW-1:0]    acc_reg, acc_next;
    logic [7:0]       origin_reg, origin_next;
    logic [7:0]       type_reg, type_next;
    logic [NW-1:0]    first_reg, first_next;
    logic [NW-1:0]    last_reg, last_next;
    logic [NW-1:0]    flags_reg, flags_next;
    logic [7:0]       runes_left_reg, runes_left_next;
    logic [1:0]       rune_bytes_reg, rune_bytes_next;
    eelp_pkg::role_t  role_reg, role_next;
    logic             exp_pend_reg, exp_pend_next;
    logic [1:0]       chord_pend_reg, chord_pend_next;
    logic             err_stop_reg, err_stop_next;

    // output registers
    logic             out_valid_reg;
    eelp_pkg::result_t out_reg;
    logic             skid_valid_reg;
    eelp_pkg::result_t skid_reg;

    logic             accept;
    logic [7:0]       b;
    logic             is_digit;
    logic [NW+3:0]    acc_ext;
    logic [NW+3:0]    acc_prod;
    logic [NW-1:0]    acc_sat;
    logic [1:0]       lead_extra;
    logic [1:0]       rb_after;
    logic             rune_done;
    logic             exp_sel;
    logic [1:0]       chord_sel;

    logic             res_valid;
    eelp_pkg::result_t res;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign b        = s_tdata;

    // decimal accumulate: acc*10 + digit, saturating
    assign is_digit = (b >= eelp_pkg::CHAR_ZERO) && (b <= eelp_pkg::CHAR_NINE);
    assign acc_ext  = {4'b0000, acc_reg};
    assign acc_prod = (acc_ext << 3) + (acc_ext << 1) + (NW+4)'(b[3:0]);
    assign acc_sat  = (acc_prod > (NW+4)'(eelp_pkg::SAT31)) ? eelp_pkg::SAT31
                                                           : acc_prod[NW-1:0];

    // UTF-8 lead byte: number of continuation bytes to follow
    always_comb begin
        if (b < 8'h80) begin
            lead_extra = 2'd0;
        end else if (b < 8'he0) begin
            lead_extra = 2'd1;
        end else if (b < 8'hf0) begin
            lead_extra = 2'd2;
        end else begin
            lead_extra = 2'd3;
        end
    end

    assign rb_after  = (rune_bytes_reg == 2'd0) ? lead_extra : rune_bytes_reg - 2'd1;
    assign rune_done = (rb_after == 2'd0);

    // flags of a primary event set up what follows
    assign exp_sel   = (role_reg == eelp_pkg::ROLE_PRIMARY) ? flags_reg[1] : exp_pend_reg;
    assign chord_sel = (role_reg == eelp_pkg::ROLE_PRIMARY)
                     ? (flags_reg[3] ? eelp_pkg::CHORD_TWO : eelp_pkg::CHORD_NONE)
                     : chord_pend_reg;

    // next state
    always_comb begin
        phase_next      = phase_reg;
        acc_next        = acc_reg;
        origin_next     = origin_reg;
        type_next       = type_reg;
        first_next      = first_reg;
        last_next       = last_reg;
        flags_next      = flags_reg;
        runes_left_next = runes_left_reg;
        rune_bytes_next = rune_bytes_reg;
        role_next       = role_reg;
        exp_pend_next   = exp_pend_reg;
        chord_pend_next = chord_pend_reg;
        err_stop_next   = err_stop_reg;
        if (accept && !err_stop_reg) begin
            case (phase_reg)
                eelp_pkg::PH_ORIGIN: begin
                    origin_next = b;
                    phase_next  = eelp_pkg::PH_TYPE;
                end
                eelp_pkg::PH_TYPE: begin
                    type_next  = b;
                    acc_next   = '0;
                    phase_next = eelp_pkg::PH_NUM0;
                end
                eelp_pkg::PH_NUM0, eelp_pkg::PH_NUM1,
                eelp_pkg::PH_NUM2, eelp_pkg::PH_NUM3: begin
                    if (is_digit) begin
                        acc_next = acc_sat;
                    end else if (b != eelp_pkg::CHAR_SPACE) begin
                        err_stop_next = 1'b1;
                    end else begin
                        case (phase_reg)
                            eelp_pkg::PH_NUM0: begin
                                first_next = acc_reg;
                                acc_next   = '0;
                                phase_next = eelp_pkg::PH_NUM1;
                            end
                            eelp_pkg::PH_NUM1: begin
                                last_next  = acc_reg;
                                acc_next   = '0;
                                phase_next = eelp_pkg::PH_NUM2;
                            end
                            eelp_pkg::PH_NUM2: begin
                                flags_next = acc_reg;
                                acc_next   = '0;
                                phase_next = eelp_pkg::PH_NUM3;
                            end
                            default: begin
                                // rune count stays in acc for the record
                                if (acc_reg >= RUNE_LIMIT) begin
                                    err_stop_next = 1'b1;
                                end else begin
                                    runes_left_next = acc_reg[7:0];
                                    rune_bytes_next = 2'd0;
                                    phase_next = (acc_reg[7:0] != 8'd0) ? eelp_pkg::PH_TEXT
                                                                        : eelp_pkg::PH_NEWLINE;
                                end
                            end
                        endcase
                    end
                end
                eelp_pkg::PH_TEXT: begin
                    rune_bytes_next = rb_after;
                    if (rune_done) begin
                        runes_left_next = runes_left_reg - 8'd1;
                        if (runes_left_reg == 8'd1) begin
                            phase_next = eelp_pkg::PH_NEWLINE;
                        end
                    end
                end
                default: begin
                    if (b != eelp_pkg::CHAR_NL) begin
                        err_stop_next = 1'b1;
                    end else begin
                        acc_next   = '0;
                        phase_next = eelp_pkg::PH_ORIGIN;
                        exp_pend_next   = exp_sel;
                        chord_pend_next = chord_sel;
                        if (exp_sel) begin
                            exp_pend_next = 1'b0;
                            role_next     = eelp_pkg::ROLE_EXPANSION;
                        end else if (chord_sel == eelp_pkg::CHORD_TWO) begin
                            chord_pend_next = eelp_pkg::CHORD_ONE;
                            role_next       = eelp_pkg::ROLE_CHORD1;
                        end else if (chord_sel == eelp_pkg::CHORD_ONE) begin
                            chord_pend_next = eelp_pkg::CHORD_NONE;
                            role_next       = eelp_pkg::ROLE_CHORD2;
                        end else begin
                            role_next = eelp_pkg::ROLE_PRIMARY;
                        end
                    end
                end
            endcase
        end
    end

    // result word
    always_comb begin
        res       = '0;
        res.kind  = eelp_pkg::KIND_TEXT;
        res.role  = role_reg;
        res.status = eelp_pkg::ST_OK;
        res_valid = 1'b0;
        if (accept && !err_stop_reg) begin
            case (phase_reg)
                eelp_pkg::PH_ORIGIN, eelp_pkg::PH_TYPE: begin
                    res_valid = 1'b0;
                end
                eelp_pkg::PH_NUM0, eelp_pkg::PH_NUM1,
                eelp_pkg::PH_NUM2, eelp_pkg::PH_NUM3: begin
                    if (!is_digit && b != eelp_pkg::CHAR_SPACE) begin
                        res_valid  = 1'b1;
                        res.kind   = eelp_pkg::KIND_ERROR;
                        res.status = eelp_pkg::ST_BAD_NUMBER;
                    end else if (!is_digit && phase_reg == eelp_pkg::PH_NUM3
                                 && acc_reg >= RUNE_LIMIT) begin
                        res_valid  = 1'b1;
                        res.kind   = eelp_pkg::KIND_ERROR;
                        res.status = eelp_pkg::ST_TOO_LONG;
                    end
                end
                eelp_pkg::PH_TEXT: begin
                    res_valid     = 1'b1;
                    res.text_byte = b;
                    res.rune_end  = rune_done;
                end
                default: begin
                    res_valid = 1'b1;
                    if (b != eelp_pkg::CHAR_NL) begin
                        res.kind   = eelp_pkg::KIND_ERROR;
                        res.status = eelp_pkg::ST_NO_NEWLINE;
                    end else begin
                        res.kind        = eelp_pkg::KIND_EVENT;
                        res.origin_char = origin_reg;
                        res.event_type  = type_reg;
                        res.first_pos   = first_reg;
                        res.last_pos    = last_reg;
                        res.flag_bits   = flags_reg;
                        res.rune_count  = acc_reg[7:0];
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= eelp_pkg::PH_ORIGIN;
            acc_reg        <= '0;
            origin_reg     <= '0;
            type_reg       <= '0;
            first_reg      <= '0;
            last_reg       <= '0;
            flags_reg      <= '0;
            runes_left_reg <= '0;
            rune_bytes_reg <= '0;
            role_reg       <= eelp_pkg::ROLE_PRIMARY;
            exp_pend_reg   <= 1'b0;
            chord_pend_reg <= eelp_pkg::CHORD_NONE;
            err_stop_reg   <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            acc_reg        <= acc_next;
            origin_reg     <= origin_next;
            type_reg       <= type_next;
            first_reg      <= first_next;
            last_reg       <= last_next;
            flags_reg      <= flags_next;
            runes_left_reg <= runes_left_next;
            rune_bytes_reg <= rune_bytes_next;
            role_reg       <= role_next;
            exp_pend_reg   <= exp_pend_next;
            chord_pend_reg <= chord_pend_next;
            err_stop_reg   <= err_stop_next;
        end
    end

    // result register with skid; skid only fills while the output is stalled
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (!out_valid_reg || m_tready) begin
                if (skid_valid_reg) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= res_valid;
                end
            end else if (res_valid) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end else if (res_valid) begin
            skid_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {6'b000000, out_reg.status, out_reg.rune_end, out_reg.text_byte,
                       out_reg.rune_count, out_reg.flag_bits, out_reg.last_pos,
                       out_reg.first_pos, out_reg.event_type, out_reg.origin_char,
                       out_reg.role};

endmodule

`default_nettype wire

// ===== src/eelp_checker.sv =====
// ----------------------------------------------------------------------------
// eelp_checker
// Port-level checks for the event line parser, bound into every parser instance.
// ----------------------------------------------------------------------------
`default_nettype none

`include "editor_event_line_parser_unit_assert.svh"

module eelp_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic [7:0]   s_tdata,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [135:0] m_tdata,
    input wire logic [1:0]   m_tuser
);

    logic         err_word;
    logic         txt_word;
    logic         m_stall;
    logic         err_take;
    logic         err_ok;
    logic         txt_ok;
    logic [138:0] m_word;

    assign err_word = m_tvalid && (m_tuser == eelp_pkg::KIND_ERROR);
    assign txt_word = m_tvalid && (m_tuser == eelp_pkg::KIND_TEXT);
    assign m_stall  = m_tvalid && !m_tready;
    assign err_take = err_word && m_tready;
    assign m_word   = {m_tvalid, m_tuser, m_tdata};
    assign err_ok   = (m_tdata[129:128] != eelp_pkg::ST_OK) && (m_tdata[127:2] == '0);
    assign txt_ok   = (m_tdata[129:128] == eelp_pkg::ST_OK) && (m_tdata[118:2] == '0);

    `EELP_ASSERT_NEXT(a_m_hold, aclk, aresetn, m_stall, $stable(m_word), "stalled word changed")

    // error is final: nothing may follow once it is taken
    `EELP_ASSERT_NEXT(a_err_last, aclk, aresetn, err_take, !m_tvalid, "word after sticky error")

    `EELP_ASSERT_NOW(a_err_code, aclk, aresetn, err_word, err_ok, "malformed error word")

    `EELP_ASSERT_NOW(a_txt_clean, aclk, aresetn, txt_word, txt_ok, "text word carries header")

endmodule

bind editor_event_line_parser_unit eelp_checker u_eelp_checker (.*);

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: regression bench for editor_event_line_parser_unit
// Drives byte streams of event lines, with random stalls on both sides.
// A scoreboard mirrors the parser state and checks every result word.
// A single sticky error case closes the run.
// ----------------------------------------------------------------------------

class event_line_scoreboard;
    localparam int RUNE_LIMIT = 256;

    eelp_pkg::result_t due_words[$];
    int         failures;
    int         n_text;
    int         n_events;
    int         n_faults;
    int         role_seen[4];

    // mirrored parser state
    eelp_pkg::phase_t phase;
    logic [30:0] accum;
    logic [7:0] origin_q;
    logic [7:0] type_q;
    logic [30:0] first_q;
    logic [30:0] last_q;
    logic [30:0] flags_q;
    logic [7:0] runes_left;
    logic [1:0] rune_bytes_left;
    eelp_pkg::role_t role;
    bit         expansion_due;
    logic [1:0] chord_due;
    bit         halted;

    function new();
        phase           = eelp_pkg::PH_ORIGIN;
        accum           = '0;
        origin_q        = '0;
        type_q          = '0;
        first_q         = '0;
        last_q          = '0;
        flags_q         = '0;
        runes_left      = '0;
        rune_bytes_left = '0;
        role            = eelp_pkg::ROLE_PRIMARY;
        expansion_due   = 1'b0;
        chord_due       = eelp_pkg::CHORD_NONE;
        halted          = 1'b0;
    endfunction

    function void raise_fault(eelp_pkg::status_t st);
        eelp_pkg::result_t r;
        r        = '0;
        r.kind   = eelp_pkg::KIND_ERROR;
        r.role   = role;
        r.status = st;
        due_words.push_back(r);
        halted = 1'b1;
    endfunction

    // only a primary's flags schedule what follows
    function void advance_role();
        if (role == eelp_pkg::ROLE_PRIMARY) begin
            expansion_due = flags_q[1];
            chord_due     = flags_q[3] ? eelp_pkg::CHORD_TWO : eelp_pkg::CHORD_NONE;
        end
        if (expansion_due) begin
            expansion_due = 1'b0;
            role          = eelp_pkg::ROLE_EXPANSION;
        end else if (chord_due == eelp_pkg::CHORD_TWO) begin
            chord_due = eelp_pkg::CHORD_ONE;
            role      = eelp_pkg::ROLE_CHORD1;
        end else if (chord_due == eelp_pkg::CHORD_ONE) begin
            chord_due = eelp_pkg::CHORD_NONE;
            role      = eelp_pkg::ROLE_CHORD2;
        end else begin
            role = eelp_pkg::ROLE_PRIMARY;
        end
    endfunction

    function void note_byte(logic [7:0] b);
        eelp_pkg::result_t r;
        logic [34:0] grown;
        if (halted)
            return;
        r = '0;
        case (phase)
            eelp_pkg::PH_ORIGIN: begin
                origin_q = b;
                phase    = eelp_pkg::PH_TYPE;
            end
            eelp_pkg::PH_TYPE: begin
                type_q = b;
                accum  = '0;
                phase  = eelp_pkg::PH_NUM0;
            end
            eelp_pkg::PH_NUM0, eelp_pkg::PH_NUM1, eelp_pkg::PH_NUM2, eelp_pkg::PH_NUM3: begin
                if (b >= eelp_pkg::CHAR_ZERO && b <= eelp_pkg::CHAR_NINE) begin
                    grown = {4'd0, accum} * 35'd10 + {27'd0, b}
                            - {27'd0, eelp_pkg::CHAR_ZERO};
                    accum = (grown > {4'd0, eelp_pkg::SAT31}) ? eelp_pkg::SAT31
                                                              : grown[30:0];
                end else if (b != eelp_pkg::CHAR_SPACE) begin
                    raise_fault(eelp_pkg::ST_BAD_NUMBER);
                end else if (phase == eelp_pkg::PH_NUM3) begin
                    if (accum >= 31'(RUNE_LIMIT)) begin
                        raise_fault(eelp_pkg::ST_TOO_LONG);
                    end else begin
                        runes_left      = accum[7:0];
                        rune_bytes_left = '0;
                        phase           = (runes_left != 8'd0) ? eelp_pkg::PH_TEXT
                                                               : eelp_pkg::PH_NEWLINE;
                    end
                end else begin
                    case (phase)
                        eelp_pkg::PH_NUM0: first_q = accum;
                        eelp_pkg::PH_NUM1: last_q  = accum;
                        default:           flags_q = accum;
                    endcase
                    accum = '0;
                    phase = eelp_pkg::phase_t'(phase + 1);
                end
            end
            eelp_pkg::PH_TEXT: begin
                if (rune_bytes_left == 2'd0) begin
                    if (b < 8'h80)
                        rune_bytes_left = 2'd0;
                    else if (b < 8'hE0)
                        rune_bytes_left = 2'd1;
                    else if (b < 8'hF0)
                        rune_bytes_left = 2'd2;
                    else
                        rune_bytes_left = 2'd3;
                end else begin
                    rune_bytes_left = rune_bytes_left - 2'd1;
                end
                r.kind      = eelp_pkg::KIND_TEXT;
                r.role      = role;
                r.text_byte = b;
                r.rune_end  = (rune_bytes_left == 2'd0);
                due_words.push_back(r);
                if (r.rune_end) begin
                    runes_left = runes_left - 8'd1;
                    if (runes_left == 8'd0)
                        phase = eelp_pkg::PH_NEWLINE;
                end
            end
            default: begin
                if (b != eelp_pkg::CHAR_NL) begin
                    raise_fault(eelp_pkg::ST_NO_NEWLINE);
                end else begin
                    r.kind        = eelp_pkg::KIND_EVENT;
                    r.role        = role;
                    r.origin_char = origin_q;
                    r.event_type  = type_q;
                    r.first_pos   = first_q;
                    r.last_pos    = last_q;
                    r.flag_bits   = flags_q;
                    r.rune_count  = accum[7:0];
                    due_words.push_back(r);
                    advance_role();
                    accum = '0;
                    phase = eelp_pkg::PH_ORIGIN;
                end
            end
        endcase
    endfunction

    function void match(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            failures++;
        end
    endfunction

    function void check_word(logic [1:0] kind, logic [135:0] data);
        eelp_pkg::result_t want;
        if (due_words.size() == 0) begin
            $error("result word with nothing expected (kind %0d)", kind);
            failures++;
            return;
        end
        want = due_words.pop_front();
        match("kind", 32'(want.kind), 32'(kind));
        match("role", 32'(want.role), 32'(data[1:0]));
        match("origin_char", 32'(want.origin_char), 32'(data[9:2]));
        match("event_type", 32'(want.event_type), 32'(data[17:10]));
        match("first_pos", 32'(want.first_pos), 32'(data[48:18]));
        match("last_pos", 32'(want.last_pos), 32'(data[79:49]));
        match("flag_bits", 32'(want.flag_bits), 32'(data[110:80]));
        match("rune_count", 32'(want.rune_count), 32'(data[118:111]));
        match("text_byte", 32'(want.text_byte), 32'(data[126:119]));
        match("rune_end", 32'(want.rune_end), 32'(data[127]));
        match("status", 32'(want.status), 32'(data[129:128]));
        match("pad", 32'd0, 32'(data[135:130]));
        case (kind)
            eelp_pkg::KIND_TEXT:  n_text++;
            eelp_pkg::KIND_EVENT: begin
                n_events++;
                role_seen[data[1:0]]++;
            end
            default:    n_faults++;
        endcase
    endfunction
endclass

module tb_top;
    localparam int RUNE_LIMIT = 256;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    wire logic    s_tready;
    logic [7:0]   s_tdata;
    wire logic    m_tvalid;
    logic         m_tready;
    wire logic [135:0] m_tdata;
    wire logic [1:0]   m_tuser;

    event_line_scoreboard sb = new();

    bit    idle_on;
    bit    drained;
    int    bytes_in;
    string tail_case;

    editor_event_line_parser_unit #(
        .MAX_RUNES(RUNE_LIMIT)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("editor_event_line_parser_unit regression: fail");
        $finish;
    end

    // accepted words on both sides, input first
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_byte(s_tdata);
            if (m_tvalid && m_tready)
                sb.check_word(m_tuser, m_tdata);
        end
    end

    // downstream stalls
    initial begin
        m_tready = 1'b1;
        forever begin
            @(negedge aclk);
            if (idle_on && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(negedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_byte(input logic [7:0] b);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        forever begin
            @(posedge aclk);
            if (s_tready)
                break;
        end
        bytes_in++;
        @(negedge aclk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_rune(input int len);
        case (len)
            1:       send_byte(8'($urandom_range(8'h00, 8'h7F)));
            2:       send_byte(8'($urandom_range(8'h80, 8'hDF)));
            3:       send_byte(8'($urandom_range(8'hE0, 8'hEF)));
            default: send_byte(8'($urandom_range(8'hF0, 8'hFF)));
        endcase
        repeat (len - 1) send_byte(8'($urandom_range(0, 255)));
    endtask

    function automatic string rand_number();
        int    pick;
        string s;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return "";
        if (pick < 6)
            return $sformatf("%0d", $urandom_range(0, 999));
        if (pick < 9)
            return $sformatf("%0d", $urandom_range(0, 32'h7FFF_FFFF));
        s = "";
        repeat ($urandom_range(10, 14)) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
        return s;
    endfunction

    function automatic string rand_flags();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 6)  return "0";
        if (pick < 9)  return "2";
        if (pick < 12) return "8";
        if (pick < 14) return "10";
        if (pick < 15) return "";
        return rand_number();
    endfunction

    function automatic logic [7:0] rand_header();
        if ($urandom_range(0, 15) == 0)
            return eelp_pkg::CHAR_NL;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_header_and_numbers(input int runes);
        send_byte(rand_header());
        send_byte(rand_header());
        send_text({rand_number(), " "});
        send_text({rand_number(), " "});
        send_text({rand_flags(), " "});
        if (runes == 0 && $urandom_range(0, 1) == 0)
            send_text(" ");
        else
            send_text($sformatf("%0d ", runes));
    endtask

    task automatic send_random_line(input int runes);
        send_header_and_numbers(runes);
        repeat (runes) send_rune($urandom_range(1, 4));
        send_byte(eelp_pkg::CHAR_NL);
    endtask

    function automatic int rand_runes();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(7, 40);
        return $urandom_range(0, 6);
    endfunction

    task automatic send_bad_tail();
        logic [7:0] bad;
        case ($urandom_range(0, 2))
            0: begin
                tail_case = "bad number terminator";
                send_byte(rand_header());
                send_byte(rand_header());
                send_text("1 2 ");
                send_text(rand_number());
                do bad = 8'($urandom_range(0, 255));
                while (bad == eelp_pkg::CHAR_SPACE
                       || (bad >= eelp_pkg::CHAR_ZERO && bad <= eelp_pkg::CHAR_NINE));
                send_byte(bad);
            end
            1: begin
                tail_case = "rune count too large";
                send_byte(rand_header());
                send_byte(rand_header());
                send_text("1 2 3 ");
                send_text($urandom_range(0, 1) ? "256 " : $sformatf("%0d ",
                          $urandom_range(257, 32'h7FFF_FFFF)));
            end
            default: begin
                tail_case = "missing newline";
                send_header_and_numbers(1);
                send_rune($urandom_range(1, 4));
                do bad = 8'($urandom_range(0, 255));
                while (bad == eelp_pkg::CHAR_NL);
                send_byte(bad);
            end
        endcase
        // all of this must be swallowed
        repeat (12) send_byte(8'($urandom_range(0, 255)));
        send_text("ab1 2 3 0 \n");
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        idle_on  = 1'b0;
        drained  = 1'b0;
        bytes_in = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty numbers, extreme header bytes
        send_byte(8'h00);
        send_byte(8'hFF);
        send_text("    \n");
        // newline header bytes, saturation, expansion announced, runes of each length
        send_byte(eelp_pkg::CHAR_NL);
        send_byte(eelp_pkg::CHAR_NL);
        send_text("99999999999 2147483647 2 6 ");
        send_byte(8'h00);
        send_byte(8'h7F);
        send_byte(8'h80); send_byte(8'h41);
        send_byte(8'hDF); send_byte(eelp_pkg::CHAR_NL);
        send_byte(8'hE0); send_byte(8'h00); send_byte(8'hFF);
        send_byte(8'hFF); send_byte(8'h20); send_byte(8'h30); send_byte(eelp_pkg::CHAR_NL);
        send_byte(eelp_pkg::CHAR_NL);
        // expansion carrying its own flags, which are ignored
        send_text("xE1 2 10 0 \n");
        // saturated flags: expansion then both chord args
        send_text("MX0 0 2147483648 1 q\n");
        send_text("Ex5 5 8 0 \n");
        send_text("Ax0 1 0 0 \n");
        send_text("Ax2 3 0 0 \n");
        // chord args only
        send_text("KD7 9 8 0 \n");
        send_text("Ax1 1 2 0 \n");
        send_text("Ax    \n");
        send_text("KI0 0 0 000 \n");

        idle_on = 1'b1;
        while (bytes_in < 1000) begin
            if ($urandom_range(0, 7) == 0)
                idle_on = !idle_on;
            if (!drained && bytes_in > 500) begin
                // drain fully before carrying on
                drained = 1'b1;
                s_tvalid <= 1'b0;
                @(negedge aclk);
                while (sb.due_words.size() != 0) @(negedge aclk);
                send_byte(rand_header());
                send_byte(rand_header());
                send_text("0 0 0 255 ");
                repeat (255) send_rune(1);
                send_byte(eelp_pkg::CHAR_NL);
            end
            send_random_line(rand_runes());
        end

        idle_on = 1'b0;
        while (bytes_in < 1250)
            send_random_line(rand_runes());
        send_bad_tail();
        s_tvalid <= 1'b0;

        while (sb.due_words.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Covered %0d bytes: %0d text words, %0d event records",
                 bytes_in, sb.n_text, sb.n_events);
        $display("Roles primary/expansion/chord1/chord2 %0d/%0d/%0d/%0d; closing case: %s",
                 sb.role_seen[0], sb.role_seen[1], sb.role_seen[2], sb.role_seen[3],
                 tail_case);
        if (sb.failures == 0 && sb.n_faults == 1) begin
            $display("editor_event_line_parser_unit regression: pass");
        end else begin
            $display("editor_event_line_parser_unit regression: fail");
        end
        $finish;
    end
endmodule
